// ===== hdl/bootloader_command_frame_builder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bootloader command frame builder
// Concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOOTLOADER_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH
`define BOOTLOADER_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BCFB_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define BCFB_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`else
`define BCFB_ASSERT(label, cond, msg)
`define BCFB_ASSERT_IMPL(label, pre, post, msg)
`endif

`endif

// ===== hdl/bcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// bcfb_pkg
// Types, constants and the CRC byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package bcfb_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 255;
   localparam int OP_DEPTH_DEFAULT    = 4;

   localparam logic [7:0]  START_BYTE_RESET = 8'h01;
   localparam logic [7:0]  END_BYTE_RESET   = 8'h17;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'h8408;

   // register indexes on the configuration port (paddr[2])
   localparam logic REG_START_BYTE = 1'b0;
   localparam logic REG_END_BYTE   = 1'b1;

   localparam logic MODE_HEADER  = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_DATA,
      OP_STRAY
   } op_kind_type;

   // one classified operation handed from front to back
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  value;   // command or payload byte
      logic [7:0]  len;     // saturated payload length
      logic        last;    // final payload byte of the frame
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_CMD,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_DATA,
      PH_STRAY,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_END
   } phase_type;

   // reflected CRC-16, one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/bcfb_front.sv =====
// ----------------------------------------------------------------------------
// bcfb_front
// Classify incoming items and track the open frame and bytes left.
// ----------------------------------------------------------------------------
module bcfb_front #(
   parameter int MAX_PAYLOAD = bcfb_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             mode,
   input  logic [7:0]       command,
   input  logic [7:0]       payload_length,
   input  logic [7:0]       data_byte,
   output bcfb_pkg::op_type op
);

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   logic       frame_open_ff, frame_open_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] len_sat;

   always_comb begin
      len_sat       = (payload_length > MaxLen) ? MaxLen : payload_length;
      op.value      = data_byte;
      op.len        = len_sat;
      op.last       = (bytes_left_ff == 8'd1);
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      if (mode == bcfb_pkg::MODE_HEADER) begin
         op.kind  = bcfb_pkg::OP_HEADER;
         op.value = command;
      end else if (frame_open_ff) begin
         op.kind = bcfb_pkg::OP_DATA;
      end else begin
         op.kind = bcfb_pkg::OP_STRAY;
      end
      if (accept) begin
         unique case (op.kind)
            bcfb_pkg::OP_HEADER: begin
               bytes_left_in = len_sat;
               frame_open_in = (len_sat != 8'd0);
            end
            bcfb_pkg::OP_DATA: begin
               bytes_left_in = bytes_left_ff - 8'd1;
               frame_open_in = !op.last;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ===== hdl/bcfb_op_queue.sv =====
// ----------------------------------------------------------------------------
// bcfb_op_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
`include "bootloader_command_frame_builder_core_assert.svh"

module bcfb_op_queue #(
   parameter int OP_DEPTH = bcfb_pkg::OP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_in,
   input  bcfb_pkg::op_type push_op,
   output logic             is_full,
   input  logic             pop_in,
   output bcfb_pkg::op_type head_op,
   output logic             is_empty
);

   localparam int PtrW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
   localparam int CntW = $clog2(OP_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(OP_DEPTH - 1);
   localparam logic [CntW-1:0] Full    = CntW'(OP_DEPTH);

   bcfb_pkg::op_type entry_ff [OP_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign is_full  = (count_ff == Full);
   assign is_empty = (count_ff == '0);
   assign head_op  = entry_ff[rd_ptr_ff];
   assign do_push  = push_in && !is_full;
   assign do_pop   = pop_in && !is_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   `BCFB_ASSERT(a_count_bound, count_ff <= Full, "op queue count above depth")
   `BCFB_ASSERT_IMPL(a_push_fills, push_in && !pop_in && count_ff == Full - 1'b1, ##1 is_full, "op queue did not fill")

endmodule

// ===== hdl/bcfb_back.sv =====
// ----------------------------------------------------------------------------
// bcfb_back
// Emit bytes one per cycle unless stalled, run the CRC, hold result register.
// ----------------------------------------------------------------------------
`include "bootloader_command_frame_builder_core_assert.svh"

module bcfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       start_byte,
   input  logic [7:0]       end_byte,
   input  bcfb_pkg::op_type head_op,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       out_byte,
   output logic             frame_end,
   output logic             stray_error
);

   bcfb_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          value_ff, value_in;
   logic [7:0]          len_ff, len_in;
   logic                last_ff, last_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                frame_end_ff, frame_end_in;
   logic                stray_ff, stray_in;
   logic                out_free, emit;
   logic [7:0]          byte_v;
   logic                end_v, err_v;
   logic [15:0]         crc_fin;

   assign out_free    = !out_valid_ff || pop;
   assign emit        = (phase_ff != bcfb_pkg::PH_IDLE) && out_free;
   assign crc_fin     = ~crc_ff;
   assign empty       = !out_valid_ff;
   assign out_byte    = out_byte_ff;
   assign frame_end   = frame_end_ff;
   assign stray_error = stray_ff;

   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      value_in = value_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      byte_v   = 8'd0;
      end_v    = 1'b0;
      err_v    = 1'b0;
      q_pop    = 1'b0;

      unique case (phase_ff)
         bcfb_pkg::PH_IDLE: begin
         end
         bcfb_pkg::PH_START: begin
            byte_v = start_byte;
            if (emit) begin
               crc_in   = bcfb_pkg::crc_feed(bcfb_pkg::CRC_INIT, start_byte);
               phase_in = bcfb_pkg::PH_CMD;
            end
         end
         bcfb_pkg::PH_CMD: begin
            byte_v = value_ff;
            if (emit) begin
               crc_in   = bcfb_pkg::crc_feed(crc_ff, value_ff);
               phase_in = bcfb_pkg::PH_LEN_LO;
            end
         end
         bcfb_pkg::PH_LEN_LO: begin
            byte_v = len_ff;
            if (emit) begin
               crc_in   = bcfb_pkg::crc_feed(crc_ff, len_ff);
               phase_in = bcfb_pkg::PH_LEN_HI;
            end
         end
         bcfb_pkg::PH_LEN_HI: begin
            if (emit) begin
               crc_in   = bcfb_pkg::crc_feed(crc_ff, 8'd0);
               phase_in = (len_ff == 8'd0) ? bcfb_pkg::PH_CRC_HI : bcfb_pkg::PH_IDLE;
            end
         end
         bcfb_pkg::PH_DATA: begin
            byte_v = value_ff;
            if (emit) begin
               crc_in   = bcfb_pkg::crc_feed(crc_ff, value_ff);
               phase_in = last_ff ? bcfb_pkg::PH_CRC_HI : bcfb_pkg::PH_IDLE;
            end
         end
         bcfb_pkg::PH_STRAY: begin
            err_v = 1'b1;
            if (emit) begin
               phase_in = bcfb_pkg::PH_IDLE;
            end
         end
         bcfb_pkg::PH_CRC_HI: begin
            byte_v = crc_fin[15:8];
            if (emit) begin
               phase_in = bcfb_pkg::PH_CRC_LO;
            end
         end
         bcfb_pkg::PH_CRC_LO: begin
            byte_v = crc_fin[7:0];
            if (emit) begin
               phase_in = bcfb_pkg::PH_END;
            end
         end
         bcfb_pkg::PH_END: begin
            byte_v = end_byte;
            end_v  = 1'b1;
            if (emit) begin
               crc_in   = bcfb_pkg::CRC_INIT;
               phase_in = bcfb_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = bcfb_pkg::PH_IDLE;
         end
      endcase

      // take the next operation as the current one finishes
      if (phase_in == bcfb_pkg::PH_IDLE && !q_empty) begin
         q_pop    = 1'b1;
         value_in = head_op.value;
         len_in   = head_op.len;
         last_in  = head_op.last;
         unique case (head_op.kind)
            bcfb_pkg::OP_HEADER: phase_in = bcfb_pkg::PH_START;
            bcfb_pkg::OP_DATA:   phase_in = bcfb_pkg::PH_DATA;
            default:             phase_in = bcfb_pkg::PH_STRAY;
         endcase
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      frame_end_in = frame_end_ff;
      stray_in     = stray_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_v;
         frame_end_in = end_v;
         stray_in     = err_v;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bcfb_pkg::PH_IDLE;
         crc_ff       <= bcfb_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      len_ff       <= len_in;
      last_ff      <= last_in;
      out_byte_ff  <= out_byte_in;
      frame_end_ff <= frame_end_in;
      stray_ff     <= stray_in;
   end

   `BCFB_ASSERT_IMPL(a_stray_clean, out_valid_ff && stray_ff, out_byte_ff == 8'd0 && !frame_end_ff, "stray flag with frame data")
   `BCFB_ASSERT_IMPL(a_crc_order, phase_ff == bcfb_pkg::PH_CRC_LO, $past(phase_ff) == bcfb_pkg::PH_CRC_HI || $past(phase_ff) == bcfb_pkg::PH_CRC_LO, "CRC low byte out of order")
   `BCFB_ASSERT_IMPL(a_cmd_after_start, phase_ff == bcfb_pkg::PH_CMD, $past(phase_ff) == bcfb_pkg::PH_START || $past(phase_ff) == bcfb_pkg::PH_CMD, "command byte without start byte")

endmodule

// ===== hdl/bootloader_command_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// bootloader_command_frame_builder_core
// Bootloader command framer; X-25 style CRC-16 over all but CRC and end bytes.
// ----------------------------------------------------------------------------
// A header transaction (mode 0) opens a frame and produces start byte, command,
// length low and length high (always zero); with an empty payload the CRC
// high, CRC low and end bytes follow, seven bytes in all. Each payload
// transaction produces one byte, so payload streams at full rate; the final
// payload byte adds the three closing bytes. The output sequencer emits one
// byte per cycle into a single result register, stalling while that register
// holds a byte not yet popped. A four-entry operation queue between the
// classifier and the sequencer keeps push open while a header burst is still
// draining. A payload transaction with no open frame yields one result with
// stray_error set and out_byte zero. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bootloader_command_frame_builder_core #(
   parameter int MAX_PAYLOAD = bcfb_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int OP_DEPTH    = bcfb_pkg::OP_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic        req_mode,
   input  logic [7:0]  req_command,
   input  logic [7:0]  req_payload_length,
   input  logic [7:0]  req_data_byte,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_stray_error,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]       start_byte_ff, start_byte_in;
   logic [7:0]       end_byte_ff, end_byte_in;
   logic             cfg_write;
   logic             accept;
   bcfb_pkg::op_type front_op;
   bcfb_pkg::op_type head_op;
   logic             q_empty;
   logic             q_pop;

   // configuration registers: select by paddr[2], ignore the byte offset
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            bcfb_pkg::REG_START_BYTE: start_byte_in = pwdata[7:0];
            bcfb_pkg::REG_END_BYTE:   end_byte_in   = pwdata[7:0];
            default: begin
            end
         endcase
      end
      unique case (paddr[2])
         bcfb_pkg::REG_START_BYTE: prdata = {24'd0, start_byte_ff};
         bcfb_pkg::REG_END_BYTE:   prdata = {24'd0, end_byte_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= bcfb_pkg::START_BYTE_RESET;
         end_byte_ff   <= bcfb_pkg::END_BYTE_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
      end
   end

   // a transaction enters whenever the operation queue has room
   assign accept = push && !full;

   // classify the transaction and advance the frame bookkeeping
   bcfb_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .mode           (req_mode),
      .command        (req_command),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .op             (front_op)
   );

   // hold classified operations until the sequencer takes them
   bcfb_op_queue #(
      .OP_DEPTH (OP_DEPTH)
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .push_op  (front_op),
      .is_full  (full),
      .pop_in   (q_pop),
      .head_op  (head_op),
      .is_empty (q_empty)
   );

   // emit bytes, run the CRC and drive the result register
   bcfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .start_byte  (start_byte_ff),
      .end_byte    (end_byte_ff),
      .head_op     (head_op),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .out_byte    (rsp_out_byte),
      .frame_end   (rsp_frame_end),
      .stray_error (rsp_stray_error)
   );

endmodule

// ===== bench/tb_bootloader_command_frame_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bootloader_command_frame_builder_core
// Self-checking bench for the command frame builder. A transaction-level model
// predicts every byte on the wire, with the X-25 CRC and the closing bytes,
// from each accepted transaction. A checker process compares popped results
// in order. Directed frames come first, then random frames under changing
// start and end bytes, with random gaps on both the push and pop sides.
// ----------------------------------------------------------------------------
module tb_bootloader_command_frame_builder_core;

   localparam int CLK_HALF      = 5;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 48;
   localparam int SETTLE_CYCLES = 12;   // a header burst is up to seven bytes long

   // one byte of a frame as it leaves the block
   typedef struct {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       stray_error;
   } wire_byte_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        push               = 1'b0;
   logic        full;
   logic        req_mode           = bcfb_pkg::MODE_HEADER;
   logic [7:0]  req_command        = 8'h00;
   logic [7:0]  req_payload_length = 8'h00;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        empty;
   logic        pop                = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_stray_error;
   logic        psel               = 1'b0;
   logic        penable            = 1'b0;
   logic        pwrite             = 1'b0;
   logic [2:0]  paddr              = 3'd0;
   logic [31:0] pwdata             = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   always #CLK_HALF clock = ~clock;

   bootloader_command_frame_builder_core dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_command        (req_command),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_stray_error    (rsp_stray_error),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // ---------------------------------------------------------------------------
   // Bench state: expected bytes, model of the framer, run bookkeeping
   // ---------------------------------------------------------------------------
   wire_byte_type expected_bytes[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;
   bit          tx_quiet       = 1'b0;   // sender never idles while set
   bit          rx_quiet       = 1'b0;   // receiver never stalls while set

   logic [7:0]  cfg_start = bcfb_pkg::START_BYTE_RESET;
   logic [7:0]  cfg_end   = bcfb_pkg::END_BYTE_RESET;
   logic [15:0] mdl_crc   = bcfb_pkg::CRC_INIT;
   logic [7:0]  mdl_left  = 8'h00;
   logic        mdl_open  = 1'b0;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes outstanding",
                  cycle_count, expected_bytes.size());
         $display("bootloader_command_frame_builder_core verification failed");
         $finish;
      end
   end

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s expected %h got %h",
                  cycle_count, what, want, got);
      end
   endfunction

   // Mostly back to back, sometimes a few cycles, now and then a long pause.
   function automatic int idle_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------------
   // Framer model
   // ---------------------------------------------------------------------------
   // Reflected CRC-16, one bit of the byte per step, LSB first.
   function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ b[i];
         acc = acc >> 1;
         if (fb) acc = acc ^ bcfb_pkg::CRC_POLY;
      end
      return acc;
   endfunction

   // Add a covered byte to the wire and fold it into the running CRC.
   function automatic void emit_covered(input logic [7:0] b);
      mdl_crc = crc_x25_byte(mdl_crc, b);
      expected_bytes.push_back('{b, 1'b0, 1'b0});
   endfunction

   // Append inverted CRC (high byte first) and the end byte, then close.
   function automatic void close_frame();
      logic [15:0] fcs;
      fcs = ~mdl_crc;
      expected_bytes.push_back('{fcs[15:8], 1'b0, 1'b0});
      expected_bytes.push_back('{fcs[7:0], 1'b0, 1'b0});
      expected_bytes.push_back('{cfg_end, 1'b1, 1'b0});
      mdl_crc  = bcfb_pkg::CRC_INIT;
      mdl_left = 8'h00;
      mdl_open = 1'b0;
   endfunction

   function automatic void frame_model_step(input logic mode, input logic [7:0] cmd,
                                            input logic [7:0] len, input logic [7:0] data);
      int          eff_len;
      logic [15:0] len_word;
      if (mode == bcfb_pkg::MODE_HEADER) begin
         // saturate the length; a header also drops any frame still open
         eff_len  = (len > bcfb_pkg::MAX_PAYLOAD_DEFAULT) ?
                    bcfb_pkg::MAX_PAYLOAD_DEFAULT : int'(len);
         len_word = 16'(eff_len);
         mdl_crc  = bcfb_pkg::CRC_INIT;
         emit_covered(cfg_start);
         emit_covered(cmd);
         emit_covered(len_word[7:0]);
         emit_covered(len_word[15:8]);
         mdl_left = len_word[7:0];
         mdl_open = 1'b1;
         if (mdl_left == 8'h00) close_frame();
      end else if (!mdl_open) begin
         // stray payload byte: dropped, flagged with a zero byte
         expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
      end else begin
         emit_covered(data);
         mdl_left = mdl_left - 8'd1;
         if (mdl_left == 8'h00) close_frame();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker: sample between edges, pop with random stalls
   // ---------------------------------------------------------------------------
   initial begin : result_checker
      logic          empty_s, pop_s, reset_s;
      wire_byte_type got, want;
      int            stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         empty_s             = empty;
         pop_s               = pop;
         reset_s             = reset;
         got.out_byte        = rsp_out_byte;
         got.frame_end       = rsp_frame_end;
         got.stray_error     = rsp_stray_error;
         @(posedge clock);
         // a transaction moved at this edge: compare with the oldest expectation
         if (!reset_s && pop_s && !empty_s) begin
            if (expected_bytes.size() == 0) begin
               note_mismatch("result with nothing expected, out_byte", 32'hx,
                             32'(got.out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte !== want.out_byte)
                  note_mismatch("out_byte", 32'(want.out_byte), 32'(got.out_byte));
               if (got.frame_end !== want.frame_end)
                  note_mismatch("frame_end", 32'(want.frame_end), 32'(got.frame_end));
               if (got.stray_error !== want.stray_error)
                  note_mismatch("stray_error", 32'(want.stray_error), 32'(got.stray_error));
            end
         end
         // choose pop for the next cycle
         if (reset_s) begin
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            stall_left = idle_gap(rx_quiet);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   // Offer one transaction after a random gap and hold it until it is taken.
   // Push stays high on return so that back-to-back transactions need no toggle.
   task automatic send_item(input logic mode, input logic [7:0] cmd,
                            input logic [7:0] len, input logic [7:0] data);
      int   gap;
      logic full_s;
      gap = idle_gap(tx_quiet);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_mode           <= mode;
      req_command        <= cmd;
      req_payload_length <= len;
      req_data_byte      <= data;
      forever begin
         @(negedge clock);
         full_s = full;
         @(posedge clock);
         if (!full_s) break;
      end
      frame_model_step(mode, cmd, len, data);
      items_sent++;
   endtask

   // Unused fields carry noise so that the block must ignore them.
   task automatic send_header(input logic [7:0] cmd, input logic [7:0] len);
      send_item(bcfb_pkg::MODE_HEADER, cmd, len, 8'($urandom));
   endtask

   task automatic send_payload(input logic [7:0] data);
      send_item(bcfb_pkg::MODE_PAYLOAD, 8'($urandom), 8'($urandom), data);
   endtask

   // Header plus keep payload bytes; keep below len leaves the frame open.
   task automatic send_frame(input logic [7:0] cmd, input int len, input int keep);
      send_header(cmd, 8'(len));
      repeat (keep) send_payload(8'($urandom));
   endtask

   // Drop push, wait for every expected byte, then let the pipeline settle.
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------------
   task automatic csr_write(input logic reg_idx, input logic [7:0] value);
      logic rdy;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = pready;
         @(posedge clock);
      end while (!rdy);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == bcfb_pkg::REG_START_BYTE) cfg_start = value;
      else cfg_end = value;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic reg_idx);
      logic        rdy;
      logic [31:0] rdata, want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy   = pready;
         rdata = prdata;
         @(posedge clock);
      end while (!rdy);
      psel    <= 1'b0;
      penable <= 1'b0;
      want = {24'h0, (reg_idx == bcfb_pkg::REG_START_BYTE) ? cfg_start : cfg_end};
      if (rdata !== want) note_mismatch("register read", want, rdata);
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] start_val, input logic [7:0] end_val);
      csr_write(bcfb_pkg::REG_START_BYTE, start_val);
      csr_write(bcfb_pkg::REG_END_BYTE, end_val);
      csr_read_check(bcfb_pkg::REG_START_BYTE);
      csr_read_check(bcfb_pkg::REG_END_BYTE);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Reset values of both registers, and one empty frame built with them.
   task automatic test_reset_values();
      csr_read_check(bcfb_pkg::REG_START_BYTE);
      csr_read_check(bcfb_pkg::REG_END_BYTE);
      send_header(8'h00, 8'h00);
      wait_idle();
   endtask

   // Field extremes and the special cases of the framer.
   task automatic test_directed_frames();
      // empty payload: whole frame from one header
      send_header(8'hFF, 8'h00);
      // extreme payload bytes
      send_header(8'h3C, 8'h02);
      send_payload(8'h00);
      send_payload(8'hFF);
      // stray byte with no frame open
      send_payload(8'hA5);
      // longest length announced, then abandoned at once by a new header
      send_header(8'h81, 8'hFF);
      send_header(8'h7E, 8'h01);
      send_payload(8'h55);
      // abandon part way through, into an empty frame
      send_header(8'h10, 8'h04);
      send_payload(8'hAA);
      send_payload(8'h01);
      send_header(8'h11, 8'h00);
      // strays straight after a closed frame
      send_payload(8'hFF);
      send_payload(8'h00);
      // back-to-back single-byte frames
      send_frame(8'hC3, 1, 1);
      send_frame(8'h24, 1, 1);
      wait_idle();
   endtask

   // Start and end bytes at both extremes, then back to reset values.
   task automatic test_config_extremes();
      set_config(8'h00, 8'hFF);
      send_frame(8'h5A, 1, 1);
      send_header(8'hA5, 8'h00);
      wait_idle();
      set_config(8'hFF, 8'h00);
      send_frame(8'h00, 2, 2);
      wait_idle();
      set_config(bcfb_pkg::START_BYTE_RESET, bcfb_pkg::END_BYTE_RESET);
   endtask

   // One frame with the largest payload.
   task automatic test_long_frame();
      send_frame(8'($urandom), bcfb_pkg::MAX_PAYLOAD_DEFAULT,
                 bcfb_pkg::MAX_PAYLOAD_DEFAULT);
      wait_idle();
   endtask

   // Hold the sender mid-frame until every expected byte has drained.
   task automatic test_sender_pause();
      send_header(8'($urandom), 8'h03);
      send_payload(8'($urandom));
      wait_idle();
      send_payload(8'($urandom));
      send_payload(8'($urandom));
      wait_idle();
   endtask

   // Mostly well-formed frames with random content, some broken frames and
   // strays; settings change between phases, and some phases run without gaps.
   task automatic test_random_frames();
      int unsigned base, phase_end;
      int          phase, r, len, keep;
      base  = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         r = $urandom_range(0, 3);
         unique case (r)
            0: begin
               set_config(8'h00, 8'hFF);
            end
            1: begin
               set_config(8'hFF, 8'h00);
            end
            default: begin
               set_config(8'($urandom), 8'($urandom));
            end
         endcase
         tx_quiet  = (phase % 4 == 1) || (phase % 4 == 3);
         rx_quiet  = (phase % 4 == 2) || (phase % 4 == 3);
         phase_end = items_sent + $urandom_range(10, 16);
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 2)) send_payload(8'($urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 6);
            else if (r < 97) len = $urandom_range(7, 40);
            else len = $urandom_range(41, 120);
            keep = len;
            // broken frame: stop short, the next header abandons it
            if (len > 0 && $urandom_range(0, 9) == 0) keep = $urandom_range(0, len - 1);
            send_frame(8'($urandom), len, keep);
         end
         tx_quiet = 1'b0;
         rx_quiet = 1'b0;
         wait_idle();
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_frames();
      test_config_extremes();
      test_sender_pause();
      test_long_frame();
      test_random_frames();
      wait_idle();
      if (expected_bytes.size() != 0) begin
         $display("%0d expected bytes never arrived", expected_bytes.size());
      end
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("bootloader_command_frame_builder_core verification clean");
      end else begin
         $display("bootloader_command_frame_builder_core verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bcfb_pkg.sv
hdl/bcfb_front.sv
hdl/bcfb_op_queue.sv
hdl/bcfb_back.sv
hdl/bootloader_command_frame_builder_core.sv
bench/tb_bootloader_command_frame_builder_core.sv
